// ----- hdl/tcrf_pkg.sv -----
// Shared types and codes for the TCP connection receive state machine.
// No dependencies; imported by every module in hdl/.
`default_nettype none

package tcrf_pkg;

   localparam int SEQ_W  = 32;
   localparam int WIN_W  = 16;
   localparam int LEN_W  = 16;
   localparam int FLAG_W = 8;
   localparam int STATE_W = 4;
   localparam int CTL_W  = 3;
   localparam int WAKE_W = 4;

   typedef enum logic [STATE_W-1:0] {
      ST_CLOSED      = 4'd0,
      ST_LISTEN      = 4'd1,
      ST_SYN_RECV    = 4'd2,
      ST_SYN_SENT    = 4'd3,
      ST_ESTABLISHED = 4'd4,
      ST_CLOSE_WAIT  = 4'd5,
      ST_LAST_ACK    = 4'd6,
      ST_FIN_WAIT1   = 4'd7,
      ST_FIN_WAIT2   = 4'd8,
      ST_CLOSING     = 4'd9,
      ST_TIME_WAIT   = 4'd10
   } conn_state_type;

   localparam logic [STATE_W-1:0] ST_LAST_CODE = 4'd10;

   // Flag byte bit positions
   localparam int FLAG_FIN = 0;
   localparam int FLAG_SYN = 1;
   localparam int FLAG_RST = 2;
   localparam int FLAG_ACK = 4;
   localparam logic [FLAG_W-1:0] FLAGS_SYN_ACK  = 8'h12;
   localparam logic [FLAG_W-1:0] FLAGS_ACK_ONLY = 8'h10;

   // Control packet requests
   localparam logic [CTL_W-1:0] CS_NONE      = 3'd0;
   localparam logic [CTL_W-1:0] CS_ACK       = 3'd1;
   localparam logic [CTL_W-1:0] CS_SYNACK    = 3'd2;
   localparam logic [CTL_W-1:0] CS_RST_CONN  = 3'd3;
   localparam logic [CTL_W-1:0] CS_RST_REPLY = 3'd4;

   // Wake mask bit positions
   localparam int WK_CONNECT = 0;
   localparam int WK_ACCEPT  = 1;
   localparam int WK_SEND    = 2;
   localparam int WK_RECV    = 3;

   localparam logic ACT_SEGMENT = 1'b0;
   localparam logic ACT_LOAD    = 1'b1;

   typedef struct packed {
      logic                action;
      logic [FLAG_W-1:0]   seg_flags;
      logic [SEQ_W-1:0]    seg_seq;
      logic [SEQ_W-1:0]    seg_seq_end;
      logic [SEQ_W-1:0]    seg_ack;
      logic [WIN_W-1:0]    seg_window;
      logic [LEN_W-1:0]    payload_length;
      logic [SEQ_W-1:0]    fresh_iss;
      logic [STATE_W-1:0]  load_state;
      logic [SEQ_W-1:0]    load_send_next;
      logic [WIN_W-1:0]    load_receive_window;
   } req_item_type;

   typedef struct packed {
      conn_state_type      conn_state;
      logic [CTL_W-1:0]    control_send;
      logic [LEN_W-1:0]    deliver_length;
      logic [WAKE_W-1:0]   wake_mask;
      logic                release_res;
      logic                start_timewait;
      logic                dropped;
      logic [WIN_W-1:0]    send_window;
   } rsp_item_type;

   // Connection context held between items
   typedef struct packed {
      conn_state_type      state;
      logic [SEQ_W-1:0]    snd_nxt;
      logic [SEQ_W-1:0]    snd_una;
      logic [SEQ_W-1:0]    rcv_nxt;
      logic [WIN_W-1:0]    snd_wnd;
      logic [WIN_W-1:0]    rcv_wnd;
   } conn_ctx_type;

   // Handshake status between the output stage and the top level
   typedef struct packed {
      logic load;
      logic space;
   } out_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/tcp_connection_receive_fsm.sv -----
// Top level of the TCP connection receive state machine.
// Depends on tcrf_pkg, tcrf_step and tcrf_rsp_stage.
//
// Usage:
//  - req channel: one item per handshake, either a segment header
//    (action = 0) or a local load from the socket layer (action = 1).
//  - rsp channel: exactly one result item per request item, in order.
//  - Path: an accepted item is held in the input register, processed
//    by tcrf_step and then loaded into the result register, which drives
//    rsp_valid; a result is loaded only when that register has space.
//  - Throughput: one item per cycle unless rsp stalls. The connection
//    context is updated in the same cycle the result register is loaded,
//    so the next item always sees the state left by the one before it.
//  - Stall: while rsp_ready is low and a result waits, the input register
//    still takes one more item; after that req_ready drops until the
//    result is taken. Nothing is lost or repeated.
//  - Reset: synchronous, active high; empties both registers and returns
//    the connection to CLOSED with all sequence and window values zero.
`default_nettype none

module tcp_connection_receive_fsm
   import tcrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   logic         in_vld_ff;
   logic         in_vld_in;
   req_item_type in_data_ff;
   conn_ctx_type ctx_ff;
   conn_ctx_type ctx_in;
   conn_ctx_type ctx_step;
   rsp_item_type step_rsp;
   out_ctl_type  out_ctl;
   logic         req_take;

   // Advance the held item when the result register can take it
   assign out_ctl.load = in_vld_ff && out_ctl.space;
   assign req_ready    = !in_vld_ff || out_ctl.load;
   assign req_take     = req_valid && req_ready;
   assign in_vld_in    = req_take || (in_vld_ff && !out_ctl.load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   tcrf_step u_step (
      .item     (in_data_ff),
      .ctx      (ctx_ff),
      .ctx_next (ctx_step),
      .rsp      (step_rsp)
   );

   // Commit the context only when the item's result is registered
   assign ctx_in = out_ctl.load ? ctx_step : ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '{state: ST_CLOSED, default: '0};
      end else begin
         ctx_ff <= ctx_in;
      end
   end

   tcrf_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (out_ctl.load),
      .load_data (step_rsp),
      .space     (out_ctl.space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hdl/tcrf_step.sv -----
// Combinational rules of one item: new connection context and result item.
// Depends on tcrf_pkg.
`default_nettype none

module tcrf_step
   import tcrf_pkg::*;
(
   input  req_item_type  item,
   input  conn_ctx_type  ctx,
   output conn_ctx_type  ctx_next,
   output rsp_item_type  rsp
);

   logic [SEQ_W-1:0] ack_m1;
   logic [WIN_W-1:0] rw;
   logic [SEQ_W-1:0] rcv_end;
   logic [SEQ_W-1:0] d_seq_end;
   logic [SEQ_W-1:0] d_rcv_seqend;
   logic [SEQ_W-1:0] d_ack_nxt;
   logic [SEQ_W-1:0] d_una_ack;
   logic [SEQ_W-1:0] d_una_ackm1;
   logic             in_window;
   logic             ack_advances;
   logic             ack_match;
   logic             una_behind;
   logic [FLAG_W-1:0] fl;

   assign fl           = item.seg_flags;
   assign ack_m1       = item.seg_ack - SEQ_W'(1);
   assign rw           = (ctx.rcv_wnd == '0) ? WIN_W'(1) : ctx.rcv_wnd;
   assign rcv_end      = ctx.rcv_nxt + {{(SEQ_W-WIN_W){1'b0}}, rw};
   assign d_seq_end    = item.seg_seq - rcv_end;
   assign d_rcv_seqend = ctx.rcv_nxt - item.seg_seq_end;
   assign d_ack_nxt    = item.seg_ack - ctx.snd_nxt;
   assign d_una_ack    = ctx.snd_una - item.seg_ack;
   assign d_una_ackm1  = ctx.snd_una - ack_m1;
   assign ack_match    = (item.seg_ack == ctx.snd_nxt);
   assign in_window    = d_seq_end[SEQ_W-1] &&
                         ((ctx.rcv_nxt == item.seg_seq_end) || d_rcv_seqend[SEQ_W-1]);
   assign ack_advances = (ack_match || d_ack_nxt[SEQ_W-1]) && d_una_ack[SEQ_W-1];
   assign una_behind   = d_una_ackm1[SEQ_W-1];

   always_comb begin
      ctx_next = ctx;
      rsp      = '0;

      if (item.action == ACT_LOAD) begin
         ctx_next.state   = (item.load_state > ST_LAST_CODE) ? ST_CLOSED
                            : conn_state_type'(item.load_state);
         ctx_next.snd_nxt = item.load_send_next;
         ctx_next.rcv_wnd = item.load_receive_window;
      end else if (ctx.state == ST_CLOSED) begin
         rsp.control_send = CS_RST_REPLY;
      end else if (ctx.state == ST_LISTEN) begin
         if (fl[FLAG_SYN]) begin
            ctx_next.snd_nxt = item.fresh_iss + SEQ_W'(1);
            ctx_next.snd_una = item.fresh_iss - SEQ_W'(1);
            ctx_next.rcv_nxt = item.seg_seq + SEQ_W'(1);
            ctx_next.snd_wnd = item.seg_window;
            ctx_next.state   = ST_SYN_RECV;
            rsp.control_send = CS_SYNACK;
         end else if (!fl[FLAG_RST]) begin
            rsp.control_send = CS_RST_REPLY;
         end
      end else if (ctx.state == ST_SYN_SENT) begin
         if (fl == FLAGS_SYN_ACK && ack_match) begin
            ctx_next.state   = ST_ESTABLISHED;
            ctx_next.snd_una = ack_m1;
            ctx_next.rcv_nxt = item.seg_seq + SEQ_W'(1);
            ctx_next.snd_wnd = item.seg_window;
            rsp.control_send = CS_ACK;
            rsp.wake_mask[WK_CONNECT] = 1'b1;
         end else begin
            rsp.control_send = CS_RST_CONN;
            rsp.release_res  = 1'b1;
         end
      end else if (!in_window) begin
         rsp.dropped = 1'b1;
      end else if (fl[FLAG_RST]) begin
         ctx_next.state  = ST_CLOSED;
         rsp.release_res = 1'b1;
      end else if (fl[FLAG_SYN] || !fl[FLAG_ACK]) begin
         rsp.control_send = CS_RST_REPLY;
         ctx_next.state   = ST_CLOSED;
         rsp.release_res  = 1'b1;
      end else if (ctx.state == ST_SYN_RECV) begin
         if (ack_match) begin
            ctx_next.state   = ST_ESTABLISHED;
            ctx_next.snd_una = ack_m1;
            ctx_next.snd_wnd = item.seg_window;
            rsp.wake_mask[WK_ACCEPT] = 1'b1;
         end
      end else begin
         if (ack_advances) begin
            if (ctx.snd_wnd == '0) begin
               rsp.wake_mask[WK_SEND] = 1'b1;
            end
            ctx_next.snd_wnd = item.seg_window;
         end
         if (ctx_next.state == ST_FIN_WAIT1 && ack_match) begin
            ctx_next.state = ST_FIN_WAIT2;
         end
         if (ctx_next.state == ST_LAST_ACK && ack_match) begin
            ctx_next.state = ST_CLOSED;
         end
         if (fl[FLAG_FIN]) begin
            if (ctx_next.state == ST_ESTABLISHED) begin
               rsp.wake_mask[WK_RECV] = 1'b1;
               ctx_next.state   = ST_CLOSE_WAIT;
               ctx_next.rcv_nxt = item.seg_seq + SEQ_W'(1);
               if (una_behind) begin
                  ctx_next.snd_una = ack_m1;
               end
               rsp.control_send = CS_ACK;
            end else if (ctx_next.state == ST_FIN_WAIT2) begin
               ctx_next.state   = ST_TIME_WAIT;
               ctx_next.rcv_nxt = item.seg_seq + SEQ_W'(1);
               if (una_behind) begin
                  ctx_next.snd_una = ack_m1;
               end
               rsp.control_send   = CS_ACK;
               rsp.start_timewait = 1'b1;
            end
         end else if (fl == FLAGS_ACK_ONLY) begin
            ctx_next.snd_una = ack_m1;
         end else begin
            rsp.deliver_length = item.payload_length;
            ctx_next.rcv_nxt   = ctx.rcv_nxt + {{(SEQ_W-LEN_W){1'b0}}, item.payload_length};
            ctx_next.snd_una   = ack_m1;
            rsp.wake_mask[WK_RECV] = 1'b1;
            rsp.control_send   = CS_ACK;
         end
      end

      rsp.conn_state  = ctx_next.state;
      rsp.send_window = ctx_next.snd_wnd;
   end

endmodule

`default_nettype wire

// ----- hdl/tcrf_rsp_stage.sv -----
// Result register with valid flag; reports when it can take a new item.
// Depends on tcrf_pkg.
`default_nettype none

module tcrf_rsp_stage
   import tcrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_data,
   output logic         space,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   logic         vld_ff;
   logic         vld_in;
   rsp_item_type data_ff;

   // Free when empty or the item is leaving this cycle
   assign space  = !vld_ff || rsp_ready;
   assign vld_in = load || (vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/tcrf_checker.sv -----
// Port-level checks for tcp_connection_receive_fsm, attached by bind.
// Depends on tcrf_pkg.
`default_nettype none

module tcrf_checker
   import tcrf_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_item_type rsp_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Nothing is shown in the first cycle after reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // A SYN|ACK request only comes with the move to SYN_RECV
   a_synack_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.control_send == CS_SYNACK |->
         rsp_data.conn_state == ST_SYN_RECV)
      else $error("SYN|ACK outside SYN_RECV");

   // Time-wait start implies TIME_WAIT and an ACK
   a_timewait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.start_timewait |->
         rsp_data.conn_state == ST_TIME_WAIT && rsp_data.control_send == CS_ACK)
      else $error("time-wait start without TIME_WAIT");

   // A dropped segment has no other effect
   a_drop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |->
         rsp_data.control_send == CS_NONE && rsp_data.deliver_length == '0 &&
         !rsp_data.release_res && rsp_data.wake_mask == '0)
      else $error("dropped segment had side effects");

endmodule

bind tcp_connection_receive_fsm tcrf_checker u_tcrf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- verif/tcrf_conn_tracker_pkg.sv -----
`timescale 1ns / 100ps
// Connection tracker for the TCP receive state machine testbench: keeps its own
// copy of the connection context, works out the response to each item and checks
// responses in order. Depends on tcrf_pkg.

package tcrf_conn_tracker_pkg;
   import tcrf_pkg::*;

   localparam logic [FLAG_W-1:0] FL_FIN = FLAG_W'(1 << FLAG_FIN);
   localparam logic [FLAG_W-1:0] FL_SYN = FLAG_W'(1 << FLAG_SYN);
   localparam logic [FLAG_W-1:0] FL_RST = FLAG_W'(1 << FLAG_RST);
   localparam logic [FLAG_W-1:0] FL_PSH = 8'h08;
   localparam logic [FLAG_W-1:0] FL_ACK = FLAG_W'(1 << FLAG_ACK);

   localparam int REPORT_LIMIT = 10;

   class conn_tracker;
      conn_state_type   cur_state;
      logic [SEQ_W-1:0] nxt_send;
      logic [SEQ_W-1:0] oldest_unacked;
      logic [SEQ_W-1:0] nxt_receive;
      logic [WIN_W-1:0] peer_window;
      logic [WIN_W-1:0] local_window;

      rsp_item_type     pending_responses[$];

      int mismatch_count;
      int responses_checked;
      int items_taken;
      int loads_taken;
      int drops_seen;
      int deliveries_seen;
      logic [ST_LAST_CODE:0] states_seen;

      function new();
         cur_state      = ST_CLOSED;
         nxt_send       = '0;
         oldest_unacked = '0;
         nxt_receive    = '0;
         peer_window    = '0;
         local_window   = '0;
         states_seen    = '0;
         mismatch_count    = 0;
         responses_checked = 0;
         items_taken       = 0;
         loads_taken       = 0;
         drops_seen        = 0;
         deliveries_seen   = 0;
      endfunction

      // modulo 2^32 ordering of sequence numbers
      function bit seq_before(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
         logic [SEQ_W-1:0] diff;
         diff = a - b;
         return diff[SEQ_W-1];
      endfunction

      function bit seq_not_after(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
         return (a == b) || seq_before(a, b);
      endfunction

      // Apply one accepted item to the shadow context and queue its response.
      function void take_item(req_item_type it);
         rsp_item_type     r;
         conn_state_type   was;
         logic [SEQ_W-1:0] span;
         logic [SEQ_W-1:0] rcv_end;
         logic [SEQ_W-1:0] ack_less;
         r = '0;
         r.control_send = CS_NONE;
         was = cur_state;
         ack_less = it.seg_ack - 32'd1;
         items_taken++;

         if (it.action == ACT_LOAD) begin
            loads_taken++;
            cur_state    = (it.load_state > ST_LAST_CODE) ? ST_CLOSED
                                                           : conn_state_type'(it.load_state);
            nxt_send     = it.load_send_next;
            local_window = it.load_receive_window;
         end else if (was == ST_CLOSED) begin
            r.control_send = CS_RST_REPLY;
         end else if (was == ST_LISTEN) begin
            if (it.seg_flags[FLAG_SYN]) begin
               nxt_send       = it.fresh_iss + 32'd1;
               oldest_unacked = it.fresh_iss - 32'd1;
               nxt_receive    = it.seg_seq + 32'd1;
               peer_window    = it.seg_window;
               cur_state      = ST_SYN_RECV;
               r.control_send = CS_SYNACK;
            end else if (!it.seg_flags[FLAG_RST]) begin
               r.control_send = CS_RST_REPLY;
            end
         end else if (was == ST_SYN_SENT) begin
            if (it.seg_flags == FLAGS_SYN_ACK && it.seg_ack == nxt_send) begin
               cur_state      = ST_ESTABLISHED;
               oldest_unacked = ack_less;
               nxt_receive    = it.seg_seq + 32'd1;
               peer_window    = it.seg_window;
               r.control_send = CS_ACK;
               r.wake_mask[WK_CONNECT] = 1'b1;
            end else begin
               r.control_send = CS_RST_CONN;
               r.release_res  = 1'b1;
            end
         end else begin
            // a closed receive window still admits one sequence number
            span    = (local_window == '0) ? 32'd1 : 32'(local_window);
            rcv_end = nxt_receive + span;
            if (!(seq_before(it.seg_seq, rcv_end) &&
                  seq_not_after(nxt_receive, it.seg_seq_end))) begin
               r.dropped = 1'b1;
            end else if (it.seg_flags[FLAG_RST]) begin
               cur_state     = ST_CLOSED;
               r.release_res = 1'b1;
            end else if (it.seg_flags[FLAG_SYN] || !it.seg_flags[FLAG_ACK]) begin
               r.control_send = CS_RST_REPLY;
               cur_state      = ST_CLOSED;
               r.release_res  = 1'b1;
            end else if (was == ST_SYN_RECV) begin
               if (it.seg_ack == nxt_send) begin
                  cur_state      = ST_ESTABLISHED;
                  oldest_unacked = ack_less;
                  peer_window    = it.seg_window;
                  r.wake_mask[WK_ACCEPT] = 1'b1;
               end
            end else begin
               if (seq_not_after(it.seg_ack, nxt_send) &&
                   seq_before(oldest_unacked, it.seg_ack)) begin
                  if (peer_window == '0) r.wake_mask[WK_SEND] = 1'b1;
                  peer_window = it.seg_window;
               end
               if (cur_state == ST_FIN_WAIT1 && it.seg_ack == nxt_send)
                  cur_state = ST_FIN_WAIT2;
               // last ACK closes the connection, the rest of the segment still applies
               if (cur_state == ST_LAST_ACK && it.seg_ack == nxt_send)
                  cur_state = ST_CLOSED;
               if (it.seg_flags[FLAG_FIN]) begin
                  // payload riding on a FIN is never delivered
                  if (cur_state == ST_ESTABLISHED) begin
                     r.wake_mask[WK_RECV] = 1'b1;
                     cur_state   = ST_CLOSE_WAIT;
                     nxt_receive = it.seg_seq + 32'd1;
                     if (seq_before(oldest_unacked, ack_less)) oldest_unacked = ack_less;
                     r.control_send = CS_ACK;
                  end
                  if (cur_state == ST_FIN_WAIT2) begin
                     cur_state   = ST_TIME_WAIT;
                     nxt_receive = it.seg_seq + 32'd1;
                     if (seq_before(oldest_unacked, ack_less)) oldest_unacked = ack_less;
                     r.control_send   = CS_ACK;
                     r.start_timewait = 1'b1;
                  end
               end else if (it.seg_flags == FLAGS_ACK_ONLY) begin
                  oldest_unacked = ack_less;
               end else begin
                  r.deliver_length = it.payload_length;
                  nxt_receive      = nxt_receive + it.payload_length;
                  oldest_unacked   = ack_less;
                  r.wake_mask[WK_RECV] = 1'b1;
                  r.control_send   = CS_ACK;
               end
            end
         end

         r.conn_state  = cur_state;
         r.send_window = peer_window;
         if (r.dropped) drops_seen++;
         if (r.deliver_length != '0) deliveries_seen++;
         states_seen[cur_state] = 1'b1;
         pending_responses.push_back(r);
      endfunction

      // Check one response against the oldest outstanding one.
      function void compare_response(rsp_item_type got);
         rsp_item_type want;
         bit           bad;
         responses_checked++;
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("[%0t] response %0d arrived with none outstanding: %h",
                        $realtime, responses_checked, got);
            return;
         end
         want = pending_responses.pop_front();
         bad = (got.conn_state     !== want.conn_state)     ||
               (got.control_send   !== want.control_send)   ||
               (got.deliver_length !== want.deliver_length) ||
               (got.wake_mask      !== want.wake_mask)      ||
               (got.release_res    !== want.release_res)    ||
               (got.start_timewait !== want.start_timewait) ||
               (got.dropped        !== want.dropped)        ||
               (got.send_window    !== want.send_window);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("[%0t] response %0d wrong", $realtime, responses_checked);
               $display("   want st=%0d ctl=%0d len=%0d wake=%h rel=%b tw=%b drop=%b wnd=%0d",
                        want.conn_state, want.control_send, want.deliver_length,
                        want.wake_mask, want.release_res, want.start_timewait,
                        want.dropped, want.send_window);
               $display("   got  st=%0d ctl=%0d len=%0d wake=%h rel=%b tw=%b drop=%b wnd=%0d",
                        got.conn_state, got.control_send, got.deliver_length,
                        got.wake_mask, got.release_res, got.start_timewait,
                        got.dropped, got.send_window);
            end
         end
      endfunction
   endclass

endpackage

// ----- verif/tcp_connection_receive_fsm_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for tcp_connection_receive_fsm: directed handshake and teardown
// sequences, then shaped random segments and loads under varying back-pressure.
// Depends on tcrf_pkg, tcrf_conn_tracker_pkg and the RTL in hdl/.

module tcp_connection_receive_fsm_tb;
   import tcrf_pkg::*;
   import tcrf_conn_tracker_pkg::*;

   localparam int RANDOM_ITEMS = 1050;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   // percentage of cycles in which each side holds back
   int send_idle_pct = 22;
   int recv_idle_pct = 47;

   conn_tracker conn = new();

   tcp_connection_receive_fsm u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Offer one item, optionally after a random idle stretch, and hold it until
   // the block takes it. Valid stays high straight into the next item when no
   // gap is drawn, so back-to-back items never drop valid.
   task automatic send_item(input req_item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      conn.take_item(it);
   endtask

   function automatic req_item_type seg_item(logic [FLAG_W-1:0] flags,
                                             logic [SEQ_W-1:0] seq,
                                             logic [SEQ_W-1:0] seq_end,
                                             logic [SEQ_W-1:0] ack,
                                             logic [WIN_W-1:0] win,
                                             logic [LEN_W-1:0] len);
      req_item_type it;
      it.action              = ACT_SEGMENT;
      it.seg_flags           = flags;
      it.seg_seq             = seq;
      it.seg_seq_end         = seq_end;
      it.seg_ack             = ack;
      it.seg_window          = win;
      it.payload_length      = len;
      // fields a segment ignores still carry noise
      it.fresh_iss           = $urandom;
      it.load_state          = STATE_W'($urandom_range(15));
      it.load_send_next      = $urandom;
      it.load_receive_window = WIN_W'($urandom_range(16'hFFFF));
      return it;
   endfunction

   function automatic req_item_type load_item(logic [STATE_W-1:0] st,
                                              logic [SEQ_W-1:0] snd,
                                              logic [WIN_W-1:0] rwnd);
      req_item_type it;
      it = seg_item(FLAG_W'($urandom_range(255)), $urandom, $urandom, $urandom,
                    WIN_W'($urandom_range(16'hFFFF)), LEN_W'($urandom_range(16'hFFFF)));
      it.action              = ACT_LOAD;
      it.load_state          = st;
      it.load_send_next      = snd;
      it.load_receive_window = rwnd;
      return it;
   endfunction

   // Draw the next random item. Most are well-formed for the current state so
   // that the connection gets through its handshake and into data and teardown;
   // the rest are loads, out-of-window segments and plain noise.
   function automatic req_item_type next_random_item();
      req_item_type     it;
      int               pick;
      int               kind;
      logic [SEQ_W-1:0] span;
      it = load_item(STATE_W'($urandom_range(15)), $urandom,
                     WIN_W'($urandom_range(16'hFFFF)));
      it.action = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 6) return it;

      // reload often from CLOSED, otherwise now and then
      if (pick < 16 || (conn.cur_state == ST_CLOSED && pick < 70)) begin
         it.action = ACT_LOAD;
         if ($urandom_range(4) != 0)
            it.load_state = STATE_W'($urandom_range(ST_LISTEN, ST_LAST_CODE));
         case ($urandom_range(3))
            0: it.load_receive_window = '0;
            1: it.load_receive_window = '1;
            default: ;
         endcase
         return it;
      end

      it.action = ACT_SEGMENT;
      case (conn.cur_state)
         ST_CLOSED: ;
         ST_LISTEN: begin
            if (pick < 85) it.seg_flags[FLAG_SYN] = 1'b1;
         end
         ST_SYN_SENT: begin
            if (pick < 85) begin
               it.seg_flags = FLAGS_SYN_ACK;
               it.seg_ack   = conn.nxt_send;
            end
         end
         default: begin
            // land inside the receive window most of the time
            span = (conn.local_window == '0) ? 32'd1 : 32'(conn.local_window);
            if (pick < 92)
               it.seg_seq = conn.nxt_receive +
                            ($urandom_range(1) ? 32'd0 : $urandom_range(span - 1));
            if ($urandom_range(3) != 0) it.payload_length = LEN_W'($urandom_range(1500));
            if ($urandom_range(7) != 0) it.seg_seq_end = it.seg_seq + it.payload_length;
            kind = $urandom_range(9);
            if (kind < 6)      it.seg_ack = conn.nxt_send;
            else if (kind < 8) it.seg_ack = conn.nxt_send - $urandom_range(1, 4);
            if ($urandom_range(4) == 0) it.seg_window = '0;
            kind = $urandom_range(19);
            if (kind == 1)       it.seg_flags = FL_RST | ($urandom_range(1) ? FL_ACK : '0);
            else if (kind == 2)  it.seg_flags = FL_SYN | FL_ACK;
            else if (kind == 3)  it.seg_flags = FL_PSH;
            else if (kind < 9)   it.seg_flags = FL_ACK;
            else if (kind < 15)  it.seg_flags = FL_ACK | FL_PSH;
            else if (kind != 0)  it.seg_flags = FL_ACK | FL_FIN |
                                                ($urandom_range(1) ? FL_PSH : '0);
         end
      endcase
      return it;
   endfunction

   // Response side: check what is taken, then draw ready for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) conn.compare_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      req_item_type it;
      int           n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // CLOSED answers every segment with a reset, all-ones and all-zero fields
      it = '1;
      it.action = ACT_SEGMENT;
      send_item(it);
      send_item('0);
      // an undefined state code loads as closed
      send_item(load_item({STATE_W{1'b1}}, '1, '1));
      send_item(load_item(ST_LISTEN, '0, '0));
      // listen: RST is ignored, anything else without SYN gets a reset reply
      send_item(seg_item(FL_RST, $urandom, $urandom, $urandom,
                         WIN_W'($urandom_range(16'hFFFF)), '0));
      send_item(seg_item(FL_ACK, $urandom, $urandom, $urandom,
                         WIN_W'($urandom_range(16'hFFFF)), '0));
      // SYN with wrapping sequence numbers opens the child
      it = seg_item(FL_SYN, '1, '1, '0, '0, '0);
      it.fresh_iss = '1;
      send_item(it);
      // matching ACK completes the passive open; zero window admits one number
      send_item(seg_item(FL_ACK, conn.nxt_receive, conn.nxt_receive, conn.nxt_send,
                         16'd1000, '0));
      send_item(seg_item(FL_ACK | FL_PSH, conn.nxt_receive, conn.nxt_receive + 100,
                         conn.nxt_send, 16'd2000, 16'd100));
      // outside the one-wide window: drop
      send_item(seg_item(FL_ACK, conn.nxt_receive + 5, conn.nxt_receive + 5,
                         conn.nxt_send, '1, '0));
      // SYN on an open connection aborts it
      send_item(seg_item(FL_SYN | FL_ACK, conn.nxt_receive, conn.nxt_receive,
                         conn.nxt_send, '1, '0));
      // segment without ACK aborts too
      send_item(load_item(ST_ESTABLISHED, $urandom, '1));
      send_item(seg_item(FL_PSH, conn.nxt_receive, conn.nxt_receive + 8,
                         conn.nxt_send, '1, 16'd8));
      // RST inside a wide window
      send_item(load_item(ST_ESTABLISHED, $urandom, '1));
      send_item(seg_item(FL_RST, conn.nxt_receive + 1000, conn.nxt_receive + 1000,
                         $urandom, '1, '0));
      // active close: FIN_WAIT1, ACK of our FIN, then peer FIN with payload
      send_item(load_item(ST_FIN_WAIT1, $urandom, 16'd512));
      send_item(seg_item(FL_ACK, conn.nxt_receive, conn.nxt_receive, conn.nxt_send,
                         16'd300, '0));
      send_item(seg_item(FL_FIN | FL_ACK, conn.nxt_receive, conn.nxt_receive + 50,
                         conn.nxt_send, 16'd300, 16'd50));
      // passive close: FIN carrying data moves to CLOSE_WAIT, data not delivered
      send_item(load_item(ST_ESTABLISHED, conn.nxt_send, 16'd4096));
      send_item(seg_item(FL_FIN | FL_ACK | FL_PSH, conn.nxt_receive + 10,
                         conn.nxt_receive + 30, conn.nxt_send, '0, 16'd20));
      // LAST_ACK closed by the final ACK
      send_item(load_item(ST_LAST_ACK, $urandom, 16'd100));
      send_item(seg_item(FL_ACK, conn.nxt_receive, conn.nxt_receive, conn.nxt_send,
                         '0, '0));
      // active open: good SYN|ACK, then a bad answer that resets the connection
      send_item(load_item(ST_SYN_SENT, $urandom, 16'd100));
      send_item(seg_item(FLAGS_SYN_ACK, $urandom, $urandom, conn.nxt_send, '1, '0));
      send_item(load_item(ST_SYN_SENT, $urandom, 16'd100));
      send_item(seg_item(FL_SYN, $urandom, $urandom, conn.nxt_send, '1, '0));

      // random part in three idling phases
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 47;
            recv_idle_pct = 22;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_item(next_random_item());
      end
      req_valid <= 1'b0;

      // drain, then wait for anything stray
      while (conn.pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d items (%0d loads), %0d responses checked",
               conn.items_taken, conn.loads_taken, conn.responses_checked);
      $display("window drops %0d, data deliveries %0d, states reached %b",
               conn.drops_seen, conn.deliveries_seen, conn.states_seen);
      if (conn.mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d bad responses", conn.mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legitimate run
   initial begin
      #400000;
      $display("timed out with %0d responses outstanding", conn.pending_responses.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
